// ===== rtl/spr_pkg.sv =====
// shared types, constants and address helper for the particle splat rasterizer
package spr_pkg;

    localparam int FRAME_SIDE = 500;
    localparam int BORDER     = 10;
    localparam int PIX_COUNT  = FRAME_SIDE * FRAME_SIDE;
    localparam int ADDR_W     = $clog2(PIX_COUNT);
    localparam int COUNT_W    = 15;
    localparam int COORD_W    = 9;
    localparam int CFG_W      = 10;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // command codes
    localparam logic [1:0] CMD_CLEAR = 2'd0;
    localparam logic [1:0] CMD_SPLAT = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    // configuration register indexes
    localparam logic [1:0] REG_RADIUS  = 2'd0;
    localparam logic [1:0] REG_SCALE_X = 2'd1;
    localparam logic [1:0] REG_SCALE_Y = 2'd2;

    typedef struct packed {
        logic        [1:0]         command;
        logic signed [23:0]        pos_x;
        logic signed [23:0]        pos_y;
        logic        [COORD_W-1:0] read_col;
        logic        [COORD_W-1:0] read_row;
    } in_item_t;

    typedef struct packed {
        logic               covered;
        logic [COUNT_W-1:0] pixel_count;
    } out_item_t;

    // column-major store address: col * FRAME_SIDE + row
    function automatic logic [ADDR_W-1:0] pix_addr(
        input logic [COORD_W-1:0] col,
        input logic [COORD_W-1:0] row
    );
        logic [ADDR_W-1:0] base;
        base     = ADDR_W'(col) * ADDR_W'(FRAME_SIDE);
        pix_addr = base + ADDR_W'(row);
    endfunction

endpackage

// ===== rtl/spr_ram.sv =====
// generic simple dual-port ram with registered read
module spr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/particle_splat_rasterizer.sv =====
// particle splat rasterizer top level: command sequencer around the pixel count store
//
//  channel | signals                           | beat
//  --------+-----------------------------------+------------------------------------
//  in      | in_valid, in_ready, in_data       | one command: clear, splat or read
//  out     | out_valid, out_ready, out_data    | one result per command
//  cfg     | cfg_we, cfg_index, cfg_data       | one register write, no wait
//
//  one command at a time; splat: map, centre, then a scan of the (2e+1)^2 square,
//    e = floor(5*radius/4) - 1 (0 when that is negative), one pixel offset of the
//    square per cycle through a read-modify-write pipe, then a drain of that pipe
//  clear: one store entry written per cycle; read: one store read; unused code: zero result
//  after reset a clearing pass over every store entry runs before the first beat is taken
//  a waiting result sits in the output register while the next command is taken
module particle_splat_rasterizer (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  spr_pkg::in_item_t             in_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output spr_pkg::out_item_t            out_data,
    input  logic                          cfg_we,
    input  logic [1:0]                    cfg_index,
    input  logic [spr_pkg::CFG_W-1:0]     cfg_data
);

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MAP,
        ST_CENTRE,
        ST_SCAN,
        ST_DRAIN,
        ST_RD_ISSUE,
        ST_RD_WAIT,
        ST_DONE
    } state_t;

    state_t                             state_reg;
    spr_pkg::in_item_t                  item_reg;
    spr_pkg::out_item_t                 res_reg;
    spr_pkg::out_item_t                 out_reg;
    logic                               out_valid_reg;
    logic [spr_pkg::ADDR_W-1:0]         clr_addr_reg;
    logic                               clr_cmd_reg;
    logic                               drain_reg;

    logic [4:0]                         radius_reg;
    logic [9:0]                         scale_x_reg;
    logic [9:0]                         scale_y_reg;

    logic signed [34:0]                 prod_x_reg;
    logic signed [34:0]                 prod_y_reg;
    logic signed [19:0]                 cx_reg;
    logic signed [19:0]                 cy_reg;
    logic [9:0]                         r2_reg;
    logic [11:0]                        rl2_reg;
    logic [5:0]                         ext_reg;
    logic signed [6:0]                  dx_reg;
    logic signed [6:0]                  dy_reg;

    logic                               s1_v_reg;
    logic [1:0]                         s1_w_reg;
    logic [spr_pkg::COORD_W-1:0]        s1_x_reg;
    logic [spr_pkg::COORD_W-1:0]        s1_y_reg;
    logic                               p_v_reg;
    logic [1:0]                         p_w_reg;
    logic [spr_pkg::ADDR_W-1:0]         p_addr_reg;

    logic                               ram_we;
    logic [spr_pkg::ADDR_W-1:0]         ram_waddr;
    logic [spr_pkg::COUNT_W-1:0]        ram_wdata;
    logic                               ram_re;
    logic [spr_pkg::ADDR_W-1:0]         ram_raddr;
    logic [spr_pkg::COUNT_W-1:0]        ram_rdata;

    logic signed [34:0]                 rnd_x;
    logic signed [34:0]                 rnd_y;
    logic signed [34:0]                 q_x;
    logic signed [34:0]                 q_y;
    logic [7:0]                         rl5;
    logic [5:0]                         rl;
    logic signed [6:0]                  ext_s;
    logic [5:0]                         ax;
    logic [5:0]                         ay;
    logic [11:0]                        sq;
    logic [1:0]                         weight;
    logic signed [20:0]                 px;
    logic signed [20:0]                 py;
    logic                               px_in;
    logic                               py_in;
    logic [spr_pkg::COUNT_W:0]          sum;
    logic [spr_pkg::COUNT_W-1:0]        sat;
    logic                               rd_in_frame;
    logic                               rd_interior;
    logic [spr_pkg::COUNT_W-1:0]        rd_count;

    spr_ram #(
        .WIDTH (spr_pkg::COUNT_W),
        .DEPTH (spr_pkg::PIX_COUNT)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // centre mapping, truncation toward zero
    always_comb
    begin
        rnd_x = prod_x_reg + (prod_x_reg[34] ? 35'sd65535 : 35'sd0);
        rnd_y = prod_y_reg + (prod_y_reg[34] ? 35'sd65535 : 35'sd0);
        q_x   = rnd_x >>> 16;
        q_y   = rnd_y >>> 16;
    end

    // ring extent from the radius
    always_comb
    begin
        rl5 = {3'd0, radius_reg} * 8'd5;
        rl  = rl5[7:2];
    end

    // weight and position of the current scan offset
    always_comb
    begin
        ext_s  = $signed({1'b0, ext_reg});
        ax     = dx_reg[6] ? 6'(-dx_reg) : dx_reg[5:0];
        ay     = dy_reg[6] ? 6'(-dy_reg) : dy_reg[5:0];
        sq     = ({6'd0, ax} * {6'd0, ax}) + ({6'd0, ay} * {6'd0, ay});
        if (ax == 6'd0 && ay == 6'd0)
        begin
            weight = 2'd2;
        end
        else if (ax == 6'd0)
        begin
            weight = (ay < {1'b0, radius_reg}) ? 2'd2 : 2'd0;
        end
        else if (ay == 6'd0)
        begin
            weight = (ax < {1'b0, radius_reg}) ? 2'd2 : 2'd0;
        end
        else if (sq < {2'd0, r2_reg})
        begin
            weight = 2'd2;
        end
        else if (sq < rl2_reg)
        begin
            weight = 2'd1;
        end
        else
        begin
            weight = 2'd0;
        end
        px    = {cx_reg[19], cx_reg} + {{14{dx_reg[6]}}, dx_reg};
        py    = {cy_reg[19], cy_reg} + {{14{dy_reg[6]}}, dy_reg};
        px_in = (px > 21'(spr_pkg::BORDER)) &&
                (px < 21'(spr_pkg::FRAME_SIDE - spr_pkg::BORDER));
        py_in = (py > 21'(spr_pkg::BORDER)) &&
                (py < 21'(spr_pkg::FRAME_SIDE - spr_pkg::BORDER));
    end

    // saturating add and read answer
    always_comb
    begin
        sum         = {1'b0, ram_rdata} + {{(spr_pkg::COUNT_W-1){1'b0}}, p_w_reg};
        sat         = sum[spr_pkg::COUNT_W] ? spr_pkg::COUNT_MAX : sum[spr_pkg::COUNT_W-1:0];
        rd_in_frame = (item_reg.read_col < 9'(spr_pkg::FRAME_SIDE)) &&
                      (item_reg.read_row < 9'(spr_pkg::FRAME_SIDE));
        rd_interior = (item_reg.read_col > 9'(spr_pkg::BORDER)) &&
                      (item_reg.read_col < 9'(spr_pkg::FRAME_SIDE - spr_pkg::BORDER)) &&
                      (item_reg.read_row > 9'(spr_pkg::BORDER)) &&
                      (item_reg.read_row < 9'(spr_pkg::FRAME_SIDE - spr_pkg::BORDER));
        rd_count    = rd_in_frame ? ram_rdata : '0;
    end

    // store ports
    always_comb
    begin
        if (state_reg == ST_CLEAR)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_addr_reg;
            ram_wdata = '0;
        end
        else
        begin
            ram_we    = p_v_reg;
            ram_waddr = p_addr_reg;
            ram_wdata = sat;
        end
        if (state_reg == ST_RD_ISSUE)
        begin
            ram_re    = rd_in_frame;
            ram_raddr = spr_pkg::pix_addr(item_reg.read_col, item_reg.read_row);
        end
        else
        begin
            ram_re    = s1_v_reg;
            ram_raddr = spr_pkg::pix_addr(s1_x_reg, s1_y_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
            clr_addr_reg  <= '0;
            clr_cmd_reg   <= 1'b0;
            drain_reg     <= 1'b0;
            radius_reg    <= 5'd9;
            scale_x_reg   <= 10'd480;
            scale_y_reg   <= 10'd480;
            s1_v_reg      <= 1'b0;
            p_v_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    spr_pkg::REG_RADIUS:  radius_reg  <= cfg_data[4:0];
                    spr_pkg::REG_SCALE_X: scale_x_reg <= cfg_data;
                    spr_pkg::REG_SCALE_Y: scale_y_reg <= cfg_data;
                    default: ;
                endcase
            end

            // the done state reloads the output register itself
            if (out_valid_reg && out_ready && state_reg != ST_DONE)
            begin
                out_valid_reg <= 1'b0;
            end

            // read-modify-write pipe moves every cycle
            p_v_reg    <= s1_v_reg;
            p_w_reg    <= s1_w_reg;
            p_addr_reg <= spr_pkg::pix_addr(s1_x_reg, s1_y_reg);
            s1_v_reg   <= (state_reg == ST_SCAN) && (weight != 2'd0) && px_in && py_in;

            unique case (state_reg)
                ST_CLEAR:
                begin
                    if (clr_addr_reg == spr_pkg::ADDR_W'(spr_pkg::PIX_COUNT - 1))
                    begin
                        clr_addr_reg <= '0;
                        res_reg      <= '0;
                        state_reg    <= clr_cmd_reg ? ST_DONE : ST_IDLE;
                    end
                    else
                    begin
                        clr_addr_reg <= clr_addr_reg + 1'b1;
                    end
                end
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        item_reg <= in_data;
                        res_reg  <= '0;
                        unique case (in_data.command)
                            spr_pkg::CMD_CLEAR:
                            begin
                                clr_cmd_reg <= 1'b1;
                                state_reg   <= ST_CLEAR;
                            end
                            spr_pkg::CMD_SPLAT: state_reg <= ST_MAP;
                            spr_pkg::CMD_READ:  state_reg <= ST_RD_ISSUE;
                            default:            state_reg <= ST_DONE;
                        endcase
                    end
                end
                ST_MAP:
                begin
                    prod_x_reg <= item_reg.pos_x * $signed({1'b0, scale_x_reg});
                    prod_y_reg <= item_reg.pos_y * $signed({1'b0, scale_y_reg});
                    state_reg  <= ST_CENTRE;
                end
                ST_CENTRE:
                begin
                    cx_reg    <= 20'(spr_pkg::BORDER) + $signed(q_x[19:0]);
                    cy_reg    <= 20'(spr_pkg::FRAME_SIDE - spr_pkg::BORDER) - $signed(q_y[19:0]);
                    r2_reg    <= {5'd0, radius_reg} * {5'd0, radius_reg};
                    rl2_reg   <= {6'd0, rl} * {6'd0, rl};
                    ext_reg   <= (rl == 6'd0) ? 6'd0 : rl - 6'd1;
                    dx_reg    <= (rl == 6'd0) ? 7'sd0 : -$signed({1'b0, rl - 6'd1});
                    dy_reg    <= (rl == 6'd0) ? 7'sd0 : -$signed({1'b0, rl - 6'd1});
                    state_reg <= ST_SCAN;
                end
                ST_SCAN:
                begin
                    s1_w_reg <= weight;
                    s1_x_reg <= px[8:0];
                    s1_y_reg <= py[8:0];
                    if (dy_reg == ext_s)
                    begin
                        dy_reg <= -ext_s;
                        if (dx_reg == ext_s)
                        begin
                            drain_reg <= 1'b0;
                            state_reg <= ST_DRAIN;
                        end
                        else
                        begin
                            dx_reg <= dx_reg + 7'sd1;
                        end
                    end
                    else
                    begin
                        dy_reg <= dy_reg + 7'sd1;
                    end
                end
                ST_DRAIN:
                begin
                    // waits out the last read, then the last write
                    drain_reg <= 1'b1;
                    if (drain_reg)
                    begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_RD_ISSUE:
                begin
                    state_reg <= ST_RD_WAIT;
                end
                ST_RD_WAIT:
                begin
                    res_reg.pixel_count <= rd_count;
                    res_reg.covered     <= rd_interior && (rd_count > 15'd1);
                    state_reg           <= ST_DONE;
                end
                ST_DONE:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_reg       <= res_reg;
                        out_valid_reg <= 1'b1;
                        clr_cmd_reg   <= 1'b0;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule
